[src/pspt_pkg.sv]
package pspt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int ADDR_W        = 64;
    localparam int DIST_W        = 8;
    localparam int CMP_W         = 32;
    localparam int PROD_W        = DIST_W + CMP_W;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(1);

    localparam logic REG_PREFETCH_DISTANCE = 1'b0;

    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_TRAINING = 2'd1,
        ST_ACTIVE   = 2'd2
    } entry_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SCAN,
        S_INSTALL,
        S_FETCH,
        S_DIFF,
        S_ABS,
        S_UPDATE,
        S_ADD,
        S_RESULT
    } fsm_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic decide;
        logic scan_start;
        logic scan_step;
        logic install;
        logic diff;
        logic absolute;
        logic update;
        logic add;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic any_invalid;
        logic scan_done;
        logic fire;
        logic out_free;
    } status_t;

endpackage

[src/pspt_if.sv]
interface pspt_access_if;
    logic                       valid;
    logic                       ready;
    logic [pspt_pkg::ADDR_W-1:0] instr_address;
    logic [pspt_pkg::ADDR_W-1:0] data_address;

    modport source (output valid, output instr_address, output data_address, input ready);
    modport sink (input valid, input instr_address, input data_address, output ready);
endinterface

interface pspt_prefetch_if;
    logic                       valid;
    logic                       ready;
    logic                       prefetch_valid;
    logic [pspt_pkg::ADDR_W-1:0] prefetch_address;

    modport source (output valid, output prefetch_valid, output prefetch_address, input ready);
    modport sink (input valid, input prefetch_valid, input prefetch_address, output ready);
endinterface

[src/pc_stride_prefetch_table_top.sv]
// Channel    Role      Beat contents
// access     sink      instr_address, data_address
// prefetch   source    prefetch_valid, prefetch_address
// apb        config    prefetch_distance at byte address 0
//
// A hit that issues a prefetch goes through lookup, decide, fetch, diff, abs, update and add
// to the result register, any other hit skips add, a miss with a free entry goes from decide
// to install, and a miss on a full table first scans for the oldest entry, reading the age
// memory one entry per cycle through its single read port. Beats are taken only in idle.
// Reset clears the entry states and the access counter and sets the distance to one; the
// memories need no clearing. A stalled result is held while the next beat is accepted.
module pc_stride_prefetch_table_top #(
    parameter int TABLE_ENTRIES = pspt_pkg::TABLE_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pspt_access_if.sink                       access,
    pspt_prefetch_if.source                   prefetch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pspt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pspt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pspt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [pspt_pkg::DIST_W-1:0] distance_reg;
    logic                        reg_sel;
    pspt_pkg::cmd_t              cmd;
    pspt_pkg::status_t           status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[pspt_pkg::CFG_ADDR_W-1] == pspt_pkg::REG_PREFETCH_DISTANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg <= pspt_pkg::DIST_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            distance_reg <= pwdata[pspt_pkg::DIST_W-1:0];
        end
    end

    assign prdata = reg_sel ? pspt_pkg::CFG_DATA_W'(distance_reg) : '0;

    pspt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (access.valid),
        .in_ready (access.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pspt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .distance         (distance_reg),
        .instr_address    (access.instr_address),
        .data_address     (access.data_address),
        .out_valid        (prefetch.valid),
        .out_ready        (prefetch.ready),
        .prefetch_valid   (prefetch.prefetch_valid),
        .prefetch_address (prefetch.prefetch_address)
    );

endmodule

[src/pspt_ram.sv]
module pspt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pspt_ctrl.sv]
module pspt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pspt_pkg::status_t status,
    output pspt_pkg::cmd_t    cmd
);

    pspt_pkg::fsm_state_t state_reg;
    pspt_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pspt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pspt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pspt_pkg::S_LOOKUP;
                end
            end
            pspt_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = pspt_pkg::S_DECIDE;
            end
            pspt_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.hit)
                begin
                    state_next = pspt_pkg::S_FETCH;
                end
                else if (status.any_invalid)
                begin
                    state_next = pspt_pkg::S_INSTALL;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = pspt_pkg::S_SCAN;
                end
            end
            pspt_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = pspt_pkg::S_INSTALL;
                end
            end
            pspt_pkg::S_INSTALL:
            begin
                cmd.install = 1'b1;
                state_next  = pspt_pkg::S_RESULT;
            end
            pspt_pkg::S_FETCH:
            begin
                state_next = pspt_pkg::S_DIFF;
            end
            pspt_pkg::S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = pspt_pkg::S_ABS;
            end
            pspt_pkg::S_ABS:
            begin
                cmd.absolute = 1'b1;
                state_next   = pspt_pkg::S_UPDATE;
            end
            pspt_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.fire ? pspt_pkg::S_ADD : pspt_pkg::S_RESULT;
            end
            pspt_pkg::S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = pspt_pkg::S_RESULT;
            end
            pspt_pkg::S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pspt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pspt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[src/pspt_dp.sv]
module pspt_dp #(
    parameter int TABLE_ENTRIES = pspt_pkg::TABLE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pspt_pkg::cmd_t                cmd,
    output pspt_pkg::status_t             status,
    input  logic [pspt_pkg::DIST_W-1:0]   distance,
    input  logic [pspt_pkg::ADDR_W-1:0]   instr_address,
    input  logic [pspt_pkg::ADDR_W-1:0]   data_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          prefetch_valid,
    output logic [pspt_pkg::ADDR_W-1:0]   prefetch_address
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int AW    = pspt_pkg::ADDR_W;

    logic [AW-1:0]          tag_reg [TABLE_ENTRIES];
    pspt_pkg::entry_state_t est_reg [TABLE_ENTRIES];

    logic [AW-1:0]            pc_reg;
    logic [AW-1:0]            addr_reg;
    logic [AW-1:0]            stamp_reg;
    logic [AW-1:0]            counter_reg;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [TABLE_ENTRIES-1:0] inval_reg;
    logic [TABLE_ENTRIES-1:0] active_vec;
    logic [TABLE_ENTRIES-1:0] training_vec;
    logic [TABLE_ENTRIES-1:0] first_oh;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         inv_idx;
    logic [IDX_W-1:0]         sel_reg;
    logic                     hit_active_reg;
    logic                     hit_training_reg;
    logic [IDX_W-1:0]         scan_cnt_reg;
    logic [AW-1:0]            best_reg;
    logic                     scan_last;
    logic [IDX_W-1:0]         age_raddr;
    logic [AW-1:0]            age_rd;
    logic [AW-1:0]            last_rd;
    logic [AW-1:0]            stride_rd;
    logic [AW-1:0]            last_reg;
    logic [AW-1:0]            stride_reg;
    logic [AW-1:0]            diff_reg;
    logic [AW-1:0]            full_reg;
    logic                     stride_match;
    logic [pspt_pkg::PROD_W-1:0] prod_reg;
    logic                     fire_reg;
    logic [AW-1:0]            sum_reg;
    logic                     out_valid_reg;
    logic                     pf_valid_reg;
    logic [AW-1:0]            pf_addr_reg;
    logic                     last_we;
    logic                     stride_we;
    logic                     age_we;
    logic [AW-1:0]            stride_wdata;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            active_vec[i]   = (est_reg[i] == pspt_pkg::ST_ACTIVE);
            training_vec[i] = (est_reg[i] == pspt_pkg::ST_TRAINING);
        end
    end

    assign first_oh = match_reg & (~match_reg + TABLE_ENTRIES'(1));

    always_comb
    begin
        hit_idx = '0;
        inv_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (inval_reg[i])
            begin
                inv_idx = IDX_W'(i);
            end
        end
    end

    assign scan_last    = (scan_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign stride_match = (stride_reg == {{(AW - pspt_pkg::CMP_W){1'b0}},
                                          full_reg[pspt_pkg::CMP_W-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                est_reg[i] <= pspt_pkg::ST_INVALID;
            end
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                counter_reg <= counter_reg + AW'(1);
            end
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (sel_reg == IDX_W'(i))
                begin
                    if (cmd.install)
                    begin
                        est_reg[i] <= pspt_pkg::ST_TRAINING;
                    end
                    else if (cmd.update && hit_training_reg)
                    begin
                        est_reg[i] <= pspt_pkg::ST_ACTIVE;
                    end
                    else if (cmd.update && hit_active_reg && !stride_match)
                    begin
                        est_reg[i] <= pspt_pkg::ST_INVALID;
                    end
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (cmd.install && sel_reg == IDX_W'(i))
            begin
                tag_reg[i] <= pc_reg;
            end
        end
        if (cmd.capture)
        begin
            pc_reg    <= instr_address;
            addr_reg  <= data_address;
            stamp_reg <= counter_reg;
            fire_reg  <= 1'b0;
        end
        if (cmd.lookup)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                match_reg[i] <= (est_reg[i] != pspt_pkg::ST_INVALID) && (tag_reg[i] == pc_reg);
                inval_reg[i] <= (est_reg[i] == pspt_pkg::ST_INVALID);
            end
        end
        if (cmd.decide)
        begin
            sel_reg          <= (|match_reg) ? hit_idx : inv_idx;
            hit_active_reg   <= |(first_oh & active_vec);
            hit_training_reg <= |(first_oh & training_vec);
        end
        if (cmd.scan_start)
        begin
            scan_cnt_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            if (scan_cnt_reg == '0 || age_rd <= best_reg)
            begin
                best_reg <= age_rd;
                sel_reg  <= scan_cnt_reg;
            end
            scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
        end
        if (cmd.diff)
        begin
            diff_reg   <= last_rd - addr_reg;
            last_reg   <= last_rd;
            stride_reg <= stride_rd;
        end
        if (cmd.absolute)
        begin
            full_reg <= diff_reg[AW-1] ? (~diff_reg + AW'(1)) : diff_reg;
        end
        if (cmd.update)
        begin
            prod_reg <= pspt_pkg::PROD_W'(distance) *
                        pspt_pkg::PROD_W'(full_reg[pspt_pkg::CMP_W-1:0]);
            fire_reg <= hit_active_reg && stride_match;
        end
        if (cmd.add)
        begin
            sum_reg <= AW'(prod_reg) + last_reg;
        end
        if (cmd.load_out)
        begin
            pf_valid_reg <= fire_reg;
            pf_addr_reg  <= fire_reg ? sum_reg : '0;
        end
    end

    assign age_raddr    = (cmd.scan_start || scan_last) ? scan_cnt_reg & {IDX_W{cmd.scan_step}}
                                                        : scan_cnt_reg + IDX_W'(1);
    assign age_we       = cmd.install || cmd.update;
    assign last_we      = cmd.install || (cmd.update && (hit_active_reg || hit_training_reg));
    assign stride_we    = last_we;
    assign stride_wdata = cmd.install ? '0 : full_reg;

    pspt_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_ENTRIES)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (sel_reg),
        .wdata (stamp_reg),
        .raddr (age_raddr),
        .rdata (age_rd)
    );

    pspt_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_ENTRIES)
    ) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (sel_reg),
        .wdata (addr_reg),
        .raddr (sel_reg),
        .rdata (last_rd)
    );

    pspt_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_ENTRIES)
    ) u_stride_ram (
        .clk   (clk),
        .we    (stride_we),
        .waddr (sel_reg),
        .wdata (stride_wdata),
        .raddr (sel_reg),
        .rdata (stride_rd)
    );

    assign status.hit         = |match_reg;
    assign status.any_invalid = |inval_reg;
    assign status.scan_done   = scan_last;
    assign status.fire        = hit_active_reg && stride_match;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign prefetch_valid   = pf_valid_reg;
    assign prefetch_address = pf_addr_reg;

endmodule
